[rtl/zts_pkg.sv]
// ----------------------------------------------------------------------------
// zts_pkg
// Shared types, codes and defaults for the zoom tracking focus stepper.
// ----------------------------------------------------------------------------
package zts_pkg;

   localparam int unsigned REQ_W   = 4;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned DIR_W   = 2;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSRA_W  = 3;
   localparam int unsigned CNT_W   = 7;

   // Parameter defaults
   localparam int unsigned TABLE_DEPTH_DEF      = 64;
   localparam int unsigned ARRIVE_TOLERANCE_DEF = 100;
   localparam int unsigned ZOOM_DEADBAND_DEF    = 50;

   // Reset values
   localparam logic [POS_W-1:0] LIMIT_MAX_RST   = 16'd15000;
   localparam logic [CNT_W-1:0] TABLE_COUNT_RST = 7'd60;
   localparam logic [POS_W-1:0] LAST_ZOOM_RST   = 16'hFFFF;
   localparam logic [POS_W-1:0] POS_MAX         = 16'hFFFF;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TICK      = 4'd0;
   localparam logic [REQ_W-1:0] REQ_GOTO      = 4'd1;
   localparam logic [REQ_W-1:0] REQ_ZOOM      = 4'd2;
   localparam logic [REQ_W-1:0] REQ_STOP      = 4'd3;
   localparam logic [REQ_W-1:0] REQ_MOVE_UP   = 4'd4;
   localparam logic [REQ_W-1:0] REQ_MOVE_DOWN = 4'd5;
   localparam logic [REQ_W-1:0] REQ_LOAD      = 4'd6;
   localparam logic [REQ_W-1:0] REQ_POWER     = 4'd7;
   localparam logic [REQ_W-1:0] REQ_TOUCH_OFF = 4'd8;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   // Register indexes
   localparam logic [CSRA_W-1:0] CSR_LIMIT_MIN          = 3'd0;
   localparam logic [CSRA_W-1:0] CSR_LIMIT_MAX          = 3'd1;
   localparam logic [CSRA_W-1:0] CSR_SYNC_ENABLE        = 3'd2;
   localparam logic [CSRA_W-1:0] CSR_FULL_OFFSET        = 3'd3;
   localparam logic [CSRA_W-1:0] CSR_FULL_OFFSET_MINUS  = 3'd4;
   localparam logic [CSRA_W-1:0] CSR_FIRST_OFFSET       = 3'd5;
   localparam logic [CSRA_W-1:0] CSR_FIRST_OFFSET_MINUS = 3'd6;
   localparam logic [CSRA_W-1:0] CSR_TABLE_COUNT        = 3'd7;

   typedef struct packed {
      logic [POS_W-1:0] zoom;
      logic [POS_W-1:0] step;
   } zts_entry_type;

   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

[rtl/zoom_tracking_focus_stepper.sv]
// ----------------------------------------------------------------------------
// zoom_tracking_focus_stepper
// Stepper focus controller for a laser lens with zoom-tracked targets.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_* with start high; the item is taken at the
//   clock edge where start is high and busy is low.
//   Result channel: rsp_valid pulses for one cycle with the state after the
//   item (position, step line, direction, target, power). There is no
//   backpressure; the receiver must take it in that cycle.
//   Config port: csr_we/csr_index/csr_wdata writes one register per clock;
//   the user must write only while the block is idle (not enforced here).
// Sequencing:
//   Tick, goto, stop, move, load, power and touch-off items finish in the
//   accept cycle; the result shows in the next cycle and busy never rises.
//   A zoom sample that passes the deadband and sync gates runs the
//   sequencer: one table entry is scanned per clock through the table's
//   single read port, then one or two passes through the shared 17-bit
//   add/sub unit for the offset, then the goto; busy is high meanwhile.
// Reset: synchronous, active high. Motor state clears, laser off, registers
//   take their defaults, last zoom reads as 65535. Table contents are not
//   cleared and must be loaded before zoom samples use them.
// ----------------------------------------------------------------------------
module zoom_tracking_focus_stepper #(
   parameter int unsigned TABLE_DEPTH      = zts_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned ARRIVE_TOLERANCE = zts_pkg::ARRIVE_TOLERANCE_DEF,
   parameter int unsigned ZOOM_DEADBAND    = zts_pkg::ZOOM_DEADBAND_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [zts_pkg::REQ_W-1:0]   req_type,
   input  logic [zts_pkg::POS_W-1:0]   req_target_position,
   input  logic [zts_pkg::POS_W-1:0]   req_zoom_reading,
   input  logic [zts_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [zts_pkg::POS_W-1:0]   req_entry_zoom,
   input  logic [zts_pkg::POS_W-1:0]   req_entry_step,
   input  logic                        req_flag_value,
   // result channel
   output logic                        rsp_valid,
   output logic [zts_pkg::POS_W-1:0]   rsp_position,
   output logic                        rsp_step_level,
   output logic [zts_pkg::DIR_W-1:0]   rsp_direction,
   output logic                        rsp_moving,
   output logic [zts_pkg::POS_W-1:0]   rsp_target,
   output logic                        rsp_target_pending,
   output logic                        rsp_laser_on,
   // config port
   input  logic                        csr_we,
   input  logic [zts_pkg::CSRA_W-1:0]  csr_index,
   input  logic [zts_pkg::CSR_W-1:0]   csr_wdata
);
   import zts_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam logic [POS_W-1:0] TOL  = POS_W'(ARRIVE_TOLERANCE);
   localparam logic [POS_W-1:0] DBND = POS_W'(ZOOM_DEADBAND);
   localparam logic [8:0]       DEPTH9 = 9'(TABLE_DEPTH);

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,   // walk the table, one entry per clock
      ST_OFFSET = 5'b00100,   // apply calibration offset
      ST_NEGATE = 5'b01000,   // second pass for |s - off| when off > s
      ST_GOTO   = 5'b10000    // issue the goto with the computed target
   } state_type;

   state_type state_ff, state_in;

   // Config registers
   logic [POS_W-1:0] limit_min_ff, limit_min_in;
   logic [POS_W-1:0] limit_max_ff, limit_max_in;
   logic             sync_en_ff, sync_en_in;
   logic [POS_W-1:0] full_off_ff, full_off_in;
   logic             full_minus_ff, full_minus_in;
   logic [POS_W-1:0] first_off_ff, first_off_in;
   logic             first_minus_ff, first_minus_in;
   logic [CNT_W-1:0] table_cnt_ff, table_cnt_in;

   // Motor / tracking state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] end_pos_ff, end_pos_in;
   logic             move_ff, move_in;
   logic [DIR_W-1:0] dir_ff, dir_in;
   logic             track_ff, track_in;
   logic             pulse_ff, pulse_in;
   logic             power_ff, power_in;
   logic             touch_ff, touch_in;
   logic [POS_W-1:0] last_zoom_ff, last_zoom_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Zoom search datapath
   logic [POS_W-1:0] zoom_ff, zoom_in;
   logic [AW-1:0]    scan_idx_ff, scan_idx_in;
   logic [AW-1:0]    data_idx_ff, data_idx_in;
   logic             data_vld_ff, data_vld_in;
   logic [AW-1:0]    last_idx_ff, last_idx_in;
   logic [POS_W-1:0] step_ff, step_in;
   logic             first_ff, first_in;
   logic [POS_W-1:0] tgt_ff, tgt_in;

   // Table
   logic             tbl_we;
   logic [8:0]       load_idx9;
   zts_entry_type    tbl_wr_data;
   zts_entry_type    tbl_rd_data;

   // Shared add/sub unit
   logic [POS_W-1:0] alu_a, alu_b;
   logic             alu_sub;
   logic [POS_W:0]   alu_sum;

   // Entry count clamp
   logic [8:0]       cnt9, n9, last9;

   // Goto evaluation
   logic             gt_en;
   logic [POS_W-1:0] gt_pos;

   logic             accept;
   logic             stop_now;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Count of usable entries: 0 acts as 1, capped at the table depth
   assign cnt9  = 9'(table_cnt_ff);
   assign n9    = (cnt9 == 9'd0) ? 9'd1 : ((cnt9 > DEPTH9) ? DEPTH9 : cnt9);
   assign last9 = n9 - 9'd1;

   assign load_idx9       = 9'(req_entry_index);
   assign tbl_we          = accept && (req_type == REQ_LOAD) && (load_idx9 < DEPTH9);
   assign tbl_wr_data.zoom = req_entry_zoom;
   assign tbl_wr_data.step = req_entry_step;

   zts_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (load_idx9[AW-1:0]),
      .wr_data (tbl_wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (tbl_rd_data)
   );

   // Shared 17-bit add/sub. For a subtract, bit 16 set means a >= b.
   always_comb begin
      alu_a   = step_ff;
      alu_b   = first_ff ? first_off_ff : full_off_ff;
      alu_sub = first_ff ? first_minus_ff : full_minus_ff;
      if (state_ff == ST_NEGATE) begin
         alu_a   = full_off_ff;
         alu_b   = step_ff;
         alu_sub = 1'b1;
      end
   end

   assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                    + (POS_W+1)'(alu_sub);

   always_comb begin
      // defaults: hold
      state_in       = state_ff;
      limit_min_in   = limit_min_ff;
      limit_max_in   = limit_max_ff;
      sync_en_in     = sync_en_ff;
      full_off_in    = full_off_ff;
      full_minus_in  = full_minus_ff;
      first_off_in   = first_off_ff;
      first_minus_in = first_minus_ff;
      table_cnt_in   = table_cnt_ff;
      pos_in         = pos_ff;
      end_pos_in     = end_pos_ff;
      move_in        = move_ff;
      dir_in         = dir_ff;
      track_in       = track_ff;
      pulse_in       = pulse_ff;
      power_in       = power_ff;
      touch_in       = touch_ff;
      last_zoom_in   = last_zoom_ff;
      rsp_valid_in   = 1'b0;
      zoom_in        = zoom_ff;
      scan_idx_in    = scan_idx_ff;
      data_idx_in    = data_idx_ff;
      data_vld_in    = data_vld_ff;
      last_idx_in    = last_idx_ff;
      step_in        = step_ff;
      first_in       = first_ff;
      tgt_in         = tgt_ff;
      gt_en          = 1'b0;
      gt_pos         = req_target_position;
      stop_now       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_LIMIT_MIN:          limit_min_in   = csr_wdata;
            CSR_LIMIT_MAX:          limit_max_in   = csr_wdata;
            CSR_SYNC_ENABLE:        sync_en_in     = csr_wdata[0];
            CSR_FULL_OFFSET:        full_off_in    = csr_wdata;
            CSR_FULL_OFFSET_MINUS:  full_minus_in  = csr_wdata[0];
            CSR_FIRST_OFFSET:       first_off_in   = csr_wdata;
            CSR_FIRST_OFFSET_MINUS: first_minus_in = csr_wdata[0];
            CSR_TABLE_COUNT:        table_cnt_in   = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_type)
                  REQ_TICK: begin
                     if (move_ff && power_ff) begin
                        if (track_ff && (abs_diff(pos_ff, end_pos_ff) < TOL)) begin
                           stop_now = 1'b1;
                           track_in = 1'b0;
                        end else if ((pos_ff >= limit_max_ff) && (dir_ff == DIR_UP)) begin
                           stop_now = 1'b1;
                        end else if ((pos_ff <= limit_min_ff) && (dir_ff == DIR_DOWN)) begin
                           stop_now = 1'b1;
                        end else begin
                           pulse_in = ~pulse_ff;
                           if (dir_ff == DIR_UP) begin
                              pos_in = pos_ff + 16'd1;
                           end else if (dir_ff == DIR_DOWN) begin
                              pos_in = pos_ff - 16'd1;
                           end
                        end
                     end
                  end
                  REQ_GOTO: begin
                     gt_en = 1'b1;
                  end
                  REQ_ZOOM: begin
                     // pass deadband and sync gates, then start the table walk
                     if (sync_en_ff && touch_ff &&
                         (abs_diff(last_zoom_ff, req_zoom_reading) >= DBND)) begin
                        rsp_valid_in = 1'b0;
                        last_zoom_in = req_zoom_reading;
                        zoom_in      = req_zoom_reading;
                        scan_idx_in  = '0;
                        data_vld_in  = 1'b0;
                        last_idx_in  = last9[AW-1:0];
                        state_in     = ST_SCAN;
                     end
                  end
                  REQ_STOP: begin
                     stop_now = 1'b1;
                  end
                  REQ_MOVE_UP: begin
                     if (power_ff) begin
                        move_in = 1'b1;
                        dir_in  = DIR_UP;
                     end
                  end
                  REQ_MOVE_DOWN: begin
                     if (power_ff) begin
                        move_in = 1'b1;
                        dir_in  = DIR_DOWN;
                     end
                  end
                  REQ_LOAD: ;   // table write handled by tbl_we
                  REQ_POWER: begin
                     power_in = req_flag_value;
                  end
                  REQ_TOUCH_OFF: begin
                     if (power_ff && sync_en_ff) begin
                        touch_in = req_flag_value;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // address issued this cycle, data for the previous address arrives
            data_idx_in = scan_idx_ff;
            data_vld_in = 1'b1;
            if (scan_idx_ff != last_idx_ff) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (data_vld_ff &&
                ((zoom_ff >= tbl_rd_data.zoom) || (data_idx_ff == last_idx_ff))) begin
               step_in  = tbl_rd_data.step;
               first_in = (data_idx_ff == '0);
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            state_in = ST_GOTO;
            if (!alu_sub) begin
               tgt_in = alu_sum[POS_W] ? POS_MAX : alu_sum[POS_W-1:0];
            end else if (first_ff) begin
               tgt_in = alu_sum[POS_W] ? alu_sum[POS_W-1:0] : '0;
            end else if (alu_sum[POS_W]) begin
               tgt_in = alu_sum[POS_W-1:0];
            end else begin
               state_in = ST_NEGATE;
            end
         end
         ST_NEGATE: begin
            tgt_in   = alu_sum[POS_W-1:0];
            state_in = ST_GOTO;
         end
         ST_GOTO: begin
            gt_en        = 1'b1;
            gt_pos       = tgt_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // goto: track the new target, start or stop by distance
      if (gt_en) begin
         track_in   = 1'b1;
         end_pos_in = gt_pos;
         if (abs_diff(pos_ff, gt_pos) > TOL) begin
            if (power_ff) begin
               move_in = 1'b1;
               dir_in  = (pos_ff < gt_pos) ? DIR_UP : DIR_DOWN;
            end
         end else begin
            stop_now = 1'b1;
         end
      end

      if (stop_now) begin
         move_in = 1'b0;
         dir_in  = DIR_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         limit_min_ff   <= '0;
         limit_max_ff   <= LIMIT_MAX_RST;
         sync_en_ff     <= 1'b1;
         full_off_ff    <= '0;
         full_minus_ff  <= 1'b0;
         first_off_ff   <= '0;
         first_minus_ff <= 1'b0;
         table_cnt_ff   <= TABLE_COUNT_RST;
         pos_ff         <= '0;
         end_pos_ff     <= '0;
         move_ff        <= 1'b0;
         dir_ff         <= DIR_IDLE;
         track_ff       <= 1'b0;
         pulse_ff       <= 1'b0;
         power_ff       <= 1'b0;
         touch_ff       <= 1'b0;
         last_zoom_ff   <= LAST_ZOOM_RST;
         rsp_valid_ff   <= 1'b0;
         data_vld_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         limit_min_ff   <= limit_min_in;
         limit_max_ff   <= limit_max_in;
         sync_en_ff     <= sync_en_in;
         full_off_ff    <= full_off_in;
         full_minus_ff  <= full_minus_in;
         first_off_ff   <= first_off_in;
         first_minus_ff <= first_minus_in;
         table_cnt_ff   <= table_cnt_in;
         pos_ff         <= pos_in;
         end_pos_ff     <= end_pos_in;
         move_ff        <= move_in;
         dir_ff         <= dir_in;
         track_ff       <= track_in;
         pulse_ff       <= pulse_in;
         power_ff       <= power_in;
         touch_ff       <= touch_in;
         last_zoom_ff   <= last_zoom_in;
         rsp_valid_ff   <= rsp_valid_in;
         data_vld_ff    <= data_vld_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      zoom_ff     <= zoom_in;
      scan_idx_ff <= scan_idx_in;
      data_idx_ff <= data_idx_in;
      last_idx_ff <= last_idx_in;
      step_ff     <= step_in;
      first_ff    <= first_in;
      tgt_ff      <= tgt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = pos_ff;
   assign rsp_step_level     = pulse_ff;
   assign rsp_direction      = dir_ff;
   assign rsp_moving         = move_ff;
   assign rsp_target         = end_pos_ff;
   assign rsp_target_pending = track_ff;
   assign rsp_laser_on       = power_ff;

endmodule

[rtl/zts_table.sv]
// ----------------------------------------------------------------------------
// zts_table
// Zoom threshold / step target table: one write port, one registered read.
// ----------------------------------------------------------------------------
module zts_table #(
   parameter int unsigned DEPTH = zts_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  zts_pkg::zts_entry_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output zts_pkg::zts_entry_type rd_data
);
   import zts_pkg::*;

   zts_entry_type mem [DEPTH];
   zts_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/zts_checker.sv]
// ----------------------------------------------------------------------------
// zts_checker
// Port-level checks for the zoom tracking focus stepper, bound to the top.
// ----------------------------------------------------------------------------
module zts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [zts_pkg::DIR_W-1:0]   rsp_direction,
   input logic                        rsp_moving,
   input logic                        rsp_laser_on
);
   import zts_pkg::*;

   // an accepted item either answers next cycle or keeps the sequencer busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted item neither answered nor started the sequencer");

   // no result without an accept or a running sequence the cycle before
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $past(busy)))
      else $error("result strobe without a pending item");

   // moving and direction agree
   a_move_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_moving == (rsp_direction != DIR_IDLE)))
      else $error("moving flag and direction disagree");

   // motion never starts while the laser is off
   a_move_needs_power: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_moving && !$past(rsp_moving)) |-> rsp_laser_on)
      else $error("motion started with laser off");

endmodule

bind zoom_tracking_focus_stepper zts_checker u_zts_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_direction (rsp_direction),
   .rsp_moving    (rsp_moving),
   .rsp_laser_on  (rsp_laser_on)
);

[tb/zoom_tracking_focus_stepper_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoom_tracking_focus_stepper_tb
// Self-checking bench: a directed table, then random command streams over six
// register settings, checked item by item against an internal motor model.
// ----------------------------------------------------------------------------
module zoom_tracking_focus_stepper_tb;
   import zts_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned PHASE_ITEMS  = 170;
   localparam int unsigned REPORT_LINES = 40;

   // One command item and one motor snapshot, at the port widths.
   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [POS_W-1:0] goal;
      logic [POS_W-1:0] zoom;
      logic [IDX_W-1:0] slot;
      logic [POS_W-1:0] slot_zoom;
      logic [POS_W-1:0] slot_step;
      logic             flag;
   } focus_cmd_t;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             step_level;
      logic [DIR_W-1:0] direction;
      logic             moving;
      logic [POS_W-1:0] target;
      logic             target_pending;
      logic             laser_on;
   } motor_view_t;

   typedef struct packed {
      focus_cmd_t  cmd;
      logic        typed;
      motor_view_t want;
   } directed_row_t;

   // DUT ports; every input starts at a known value.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [REQ_W-1:0]     req_type = REQ_TICK;
   logic [POS_W-1:0]     req_target_position = '0;
   logic [POS_W-1:0]     req_zoom_reading = '0;
   logic [IDX_W-1:0]     req_entry_index = '0;
   logic [POS_W-1:0]     req_entry_zoom = '0;
   logic [POS_W-1:0]     req_entry_step = '0;
   logic                 req_flag_value = 1'b0;
   logic                 rsp_valid;
   logic [POS_W-1:0]     rsp_position;
   logic                 rsp_step_level;
   logic [DIR_W-1:0]     rsp_direction;
   logic                 rsp_moving;
   logic [POS_W-1:0]     rsp_target;
   logic                 rsp_target_pending;
   logic                 rsp_laser_on;
   logic                 csr_we = 1'b0;
   logic [CSRA_W-1:0]    csr_index = CSR_LIMIT_MIN;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Motor model state, at its reset values.
   logic [POS_W-1:0] mot_pos = '0;
   logic [POS_W-1:0] goal_pos = '0;
   logic             running = 1'b0;
   logic [DIR_W-1:0] run_dir = DIR_IDLE;
   logic             chasing = 1'b0;
   logic             step_line = 1'b0;
   logic             laser = 1'b0;
   logic             touched = 1'b0;
   logic [POS_W-1:0] prev_zoom = LAST_ZOOM_RST;
   logic [POS_W-1:0] zoom_tab [TABLE_DEPTH_DEF];
   logic [POS_W-1:0] step_tab [TABLE_DEPTH_DEF];

   // Register shadow, at reset defaults.
   logic [POS_W-1:0] cfg_min = '0;
   logic [POS_W-1:0] cfg_max = LIMIT_MAX_RST;
   logic             cfg_sync = 1'b1;
   logic [POS_W-1:0] cfg_full_off = '0;
   logic             cfg_full_sub = 1'b0;
   logic [POS_W-1:0] cfg_first_off = '0;
   logic             cfg_first_sub = 1'b0;
   logic [CNT_W-1:0] cfg_count = TABLE_COUNT_RST;

   motor_view_t expected_states [$];

   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned lookups = 0;
   int unsigned arrivals = 0;
   int unsigned limit_stops = 0;

   zoom_tracking_focus_stepper dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_target_position (req_target_position),
      .req_zoom_reading    (req_zoom_reading),
      .req_entry_index     (req_entry_index),
      .req_entry_zoom      (req_entry_zoom),
      .req_entry_step      (req_entry_step),
      .req_flag_value      (req_flag_value),
      .rsp_valid           (rsp_valid),
      .rsp_position        (rsp_position),
      .rsp_step_level      (rsp_step_level),
      .rsp_direction       (rsp_direction),
      .rsp_moving          (rsp_moving),
      .rsp_target          (rsp_target),
      .rsp_target_pending  (rsp_target_pending),
      .rsp_laser_on        (rsp_laser_on),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("zoom_tracking_focus_stepper_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Motor model
   // ------------------------------------------------------------------------
   function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void stop_motor();
      running = 1'b0;
      run_dir = DIR_IDLE;
   endfunction

   // Motion commands are dropped while the laser is off.
   function automatic void begin_motion(input logic [DIR_W-1:0] dir);
      if (laser) begin
         running = 1'b1;
         run_dir = dir;
      end
   endfunction

   // Goto: always latches the target; a near target halts instead.
   function automatic void head_for(input logic [POS_W-1:0] pos);
      chasing = 1'b1;
      goal_pos = pos;
      if (span(mot_pos, pos) > ARRIVE_TOLERANCE_DEF)
         begin_motion((mot_pos < pos) ? DIR_UP : DIR_DOWN);
      else
         stop_motor();
   endfunction

   function automatic motor_view_t motor_view(input logic [POS_W-1:0] pos,
                                              input logic sl,
                                              input logic [DIR_W-1:0] dir,
                                              input logic mov,
                                              input logic [POS_W-1:0] tgt,
                                              input logic pend,
                                              input logic on);
      motor_view_t v;
      v.position = pos;
      v.step_level = sl;
      v.direction = dir;
      v.moving = mov;
      v.target = tgt;
      v.target_pending = pend;
      v.laser_on = on;
      return v;
   endfunction

   // Apply one item to the model and return the snapshot the block reports.
   function automatic motor_view_t predict_focus(input focus_cmd_t c);
      int n;
      int hit;
      logic [POS_W-1:0] s;
      logic [POS_W:0] t;
      case (c.kind)
         REQ_TICK: begin
            if (running && laser) begin
               if (chasing && span(mot_pos, goal_pos) < ARRIVE_TOLERANCE_DEF) begin
                  // arrival: no step edge
                  stop_motor();
                  chasing = 1'b0;
                  arrivals++;
               end else if (mot_pos >= cfg_max && run_dir == DIR_UP) begin
                  stop_motor();
                  limit_stops++;
               end else if (mot_pos <= cfg_min && run_dir == DIR_DOWN) begin
                  stop_motor();
                  limit_stops++;
               end else begin
                  step_line = ~step_line;
                  if (run_dir == DIR_UP)
                     mot_pos = mot_pos + 1'b1;
                  else if (run_dir == DIR_DOWN)
                     mot_pos = mot_pos - 1'b1;
               end
            end
         end
         REQ_GOTO: head_for(c.goal);
         REQ_ZOOM: begin
            if (cfg_sync && touched && span(prev_zoom, c.zoom) >= ZOOM_DEADBAND_DEF) begin
               prev_zoom = c.zoom;
               n = cfg_count;
               if (n == 0)
                  n = 1;
               if (n > TABLE_DEPTH_DEF)
                  n = TABLE_DEPTH_DEF;
               // first slot at or below the reading, else the last valid one
               hit = n - 1;
               for (int k = n - 1; k >= 0; k--)
                  if (c.zoom >= zoom_tab[k])
                     hit = k;
               s = step_tab[hit];
               if (hit == 0) begin
                  if (!cfg_first_sub)
                     t = {1'b0, s} + {1'b0, cfg_first_off};
                  else
                     t = (s > cfg_first_off) ? {1'b0, s - cfg_first_off} : '0;
               end else if (!cfg_full_sub) begin
                  t = {1'b0, s} + {1'b0, cfg_full_off};
               end else begin
                  t = {1'b0, span(s, cfg_full_off)};
               end
               if (t > POS_MAX)
                  t = {1'b0, POS_MAX};
               head_for(t[POS_W-1:0]);
               lookups++;
            end
         end
         REQ_STOP: stop_motor();
         REQ_MOVE_UP: begin_motion(DIR_UP);
         REQ_MOVE_DOWN: begin_motion(DIR_DOWN);
         REQ_LOAD: begin
            zoom_tab[c.slot] = c.slot_zoom;
            step_tab[c.slot] = c.slot_step;
         end
         REQ_POWER: laser = c.flag;
         REQ_TOUCH_OFF: begin
            if (laser && cfg_sync)
               touched = c.flag;
         end
         default: ;
      endcase
      return motor_view(mot_pos, step_line, run_dir, running, goal_pos, chasing, laser);
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Register write; csr_we is then driven low and the task waits again, so csr_we gets one update per step.
   task automatic csr_write(input logic [CSRA_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LIMIT_MIN:          cfg_min = val;
         CSR_LIMIT_MAX:          cfg_max = val;
         CSR_SYNC_ENABLE:        cfg_sync = val[0];
         CSR_FULL_OFFSET:        cfg_full_off = val;
         CSR_FULL_OFFSET_MINUS:  cfg_full_sub = val[0];
         CSR_FIRST_OFFSET:       cfg_first_off = val;
         CSR_FIRST_OFFSET_MINUS: cfg_first_sub = val[0];
         CSR_TABLE_COUNT:        cfg_count = val[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_W-1:0] lo, input logic [CSR_W-1:0] hi,
                               input logic [CSR_W-1:0] sync, input logic [CSR_W-1:0] fo,
                               input logic [CSR_W-1:0] fo_sub, input logic [CSR_W-1:0] so,
                               input logic [CSR_W-1:0] so_sub, input logic [CSR_W-1:0] cnt);
      csr_write(CSR_LIMIT_MIN, lo);
      csr_write(CSR_LIMIT_MAX, hi);
      csr_write(CSR_SYNC_ENABLE, sync);
      csr_write(CSR_FULL_OFFSET, fo);
      csr_write(CSR_FULL_OFFSET_MINUS, fo_sub);
      csr_write(CSR_FIRST_OFFSET, so);
      csr_write(CSR_FIRST_OFFSET_MINUS, so_sub);
      csr_write(CSR_TABLE_COUNT, cnt);
   endtask

   // Present one item, hold it until taken, then log what it should produce.
   // start is left high so a back-to-back item needs no second update.
   task automatic issue(input focus_cmd_t c, input logic typed, input motor_view_t want);
      motor_view_t model;
      start <= 1'b1;
      req_type <= c.kind;
      req_target_position <= c.goal;
      req_zoom_reading <= c.zoom;
      req_entry_index <= c.slot;
      req_entry_zoom <= c.slot_zoom;
      req_entry_step <= c.slot_step;
      req_flag_value <= c.flag;
      do @(posedge clock); while (busy !== 1'b0);
      model = predict_focus(c);
      expected_states.push_back(typed ? want : model);
      items_sent++;
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Wait for every result owed, then let the block settle.
   task automatic drain(input int tail);
      start <= 1'b0;
      while (expected_states.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   function automatic focus_cmd_t make_cmd(input logic [REQ_W-1:0] kind,
                                           input logic [POS_W-1:0] value,
                                           input logic [IDX_W-1:0] slot,
                                           input logic [POS_W-1:0] step,
                                           input logic flag);
      focus_cmd_t c;
      c.kind = kind;
      c.goal = value;
      c.zoom = value;
      c.slot = slot;
      c.slot_zoom = value;
      c.slot_step = step;
      c.flag = flag;
      return c;
   endfunction

   // Random stream. Mostly well-formed motion: near gotos followed by ticks so
   // arrivals and limit stops happen, zoom readings around the deadband edge.
   task automatic run_phase(input int count, input int idle_pct);
      focus_cmd_t c;
      int pick;
      int r;
      int v;
      int gap;
      int burst;
      burst = 0;
      for (int k = 0; k < count; k++) begin
         // unused fields carry noise too
         c.goal = $urandom;
         c.zoom = $urandom;
         c.slot = $urandom;
         c.slot_zoom = $urandom;
         c.slot_step = $urandom;
         c.flag = $urandom;
         pick = $urandom_range(99);
         r = $urandom_range(9);
         if (pick < 38) begin
            c.kind = REQ_TICK;
         end else if (pick < 50) begin
            c.kind = REQ_GOTO;
            if (r < 6) begin
               v = int'(mot_pos) + $urandom_range(240) - 120;
               if (v < 0)
                  v = 0;
               if (v > 65535)
                  v = 65535;
               c.goal = v;
            end else if (r == 6) begin
               c.goal = '0;
            end else if (r == 7) begin
               c.goal = POS_MAX;
            end
         end else if (pick < 62) begin
            c.kind = REQ_ZOOM;
            if (r < 4) begin
               v = $urandom_range(45, 55);
               v = $urandom_range(1) ? int'(prev_zoom) + v : int'(prev_zoom) - v;
               if (v < 0)
                  v = 0;
               if (v > 65535)
                  v = 65535;
               c.zoom = v;
            end else if (r == 4) begin
               c.zoom = '0;
            end else if (r == 5) begin
               c.zoom = POS_MAX;
            end
         end else if (pick < 65) begin
            c.kind = REQ_STOP;
         end else if (pick < 70) begin
            c.kind = REQ_MOVE_UP;
         end else if (pick < 75) begin
            c.kind = REQ_MOVE_DOWN;
         end else if (pick < 81) begin
            c.kind = REQ_LOAD;
            // half the loads keep the thresholds roughly descending
            if (r < 5)
               c.slot_zoom = 16'(64000 - int'(c.slot) * 1000 + $urandom_range(500));
         end else if (pick < 88) begin
            c.kind = REQ_POWER;
            c.flag = ($urandom_range(99) < 85);
         end else if (pick < 95) begin
            c.kind = REQ_TOUCH_OFF;
            c.flag = ($urandom_range(99) < 85);
         end else begin
            c.kind = $urandom_range(9, 15);
         end
         issue(c, 1'b0, '0);

         // sender gaps, with occasional back-to-back stretches
         gap = 0;
         if (burst > 0)
            burst--;
         else if ($urandom_range(99) < 5)
            burst = $urandom_range(10, 30);
         else if ($urandom_range(99) < idle_pct)
            gap = ($urandom_range(7) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4);
         pause(gap);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
                                  input logic [POS_W-1:0] want);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Results are sampled at the edge that ends their strobe cycle.
   always @(posedge clock) begin : check_results
      motor_view_t got;
      motor_view_t want;
      if (!reset && rsp_valid !== 1'b0) begin
         got = motor_view(rsp_position, rsp_step_level, rsp_direction, rsp_moving,
                          rsp_target, rsp_target_pending, rsp_laser_on);
         results_seen++;
         if (expected_states.size() == 0) begin
            report_mismatch("result with no item waiting", got.position, '0);
         end else begin
            want = expected_states.pop_front();
            if (got.position !== want.position)
               report_mismatch("position", got.position, want.position);
            if (got.step_level !== want.step_level)
               report_mismatch("step_level", got.step_level, want.step_level);
            if (got.direction !== want.direction)
               report_mismatch("direction", got.direction, want.direction);
            if (got.moving !== want.moving)
               report_mismatch("moving", got.moving, want.moving);
            if (got.target !== want.target)
               report_mismatch("target", got.target, want.target);
            if (got.target_pending !== want.target_pending)
               report_mismatch("target_pending", got.target_pending, want.target_pending);
            if (got.laser_on !== want.laser_on)
               report_mismatch("laser_on", got.laser_on, want.laser_on);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      directed_row_t plan [$];
      directed_row_t row;
      motor_view_t   no_view;
      logic [POS_W-1:0] far_up;

      no_view = '0;
      far_up = POS_MAX;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      drain(2);

      // Phase 0: reset defaults written back explicitly.
      program_regs(16'd0, LIMIT_MAX_RST, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'(TABLE_COUNT_RST));

      // Fill the whole table first so no lookup ever touches an unwritten slot.
      for (int k = 0; k < TABLE_DEPTH_DEF; k++)
         issue(make_cmd(REQ_LOAD, 16'(63000 - k * 1000), k, $urandom, 1'b0), 1'b0, no_view);

      // Directed table. Motor state after the fill is still all zero, laser off.
      // tick from reset: nothing moves
      row = '{make_cmd(REQ_TICK, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, 16'd0, 1'b0, 1'b0)};
      plan.push_back(row);
      // move up with the laser off is dropped
      row = '{make_cmd(REQ_MOVE_UP, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, 16'd0, 1'b0, 1'b0)};
      plan.push_back(row);
      // goto with laser off: target latched, motion not started
      row = '{make_cmd(REQ_GOTO, far_up, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b0)};
      plan.push_back(row);
      // touch-off refused while laser is off
      row = '{make_cmd(REQ_TOUCH_OFF, 16'd0, 0, 16'd0, 1'b1), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b0)};
      plan.push_back(row);
      // zoom ignored without touch-off
      row = '{make_cmd(REQ_ZOOM, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b0)};
      plan.push_back(row);
      // undefined request code just reports state
      row = '{make_cmd(4'hF, 16'hA5A5, 0, 16'd0, 1'b1), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b0)};
      plan.push_back(row);
      row = '{make_cmd(REQ_POWER, 16'd0, 0, 16'd0, 1'b1), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      row = '{make_cmd(REQ_GOTO, far_up, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_UP, 1'b1, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      row = '{make_cmd(REQ_TICK, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd1, 1'b1, DIR_UP, 1'b1, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      // stop keeps the goto tracked
      row = '{make_cmd(REQ_STOP, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd1, 1'b1, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      row = '{make_cmd(REQ_MOVE_DOWN, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd1, 1'b1, DIR_DOWN, 1'b1, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      row = '{make_cmd(REQ_TICK, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_DOWN, 1'b1, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      // at the lower limit going down: halt with no step edge
      row = '{make_cmd(REQ_TICK, 16'd0, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, far_up, 1'b1, 1'b1)};
      plan.push_back(row);
      // goto exactly at the tolerance counts as already there
      row = '{make_cmd(REQ_GOTO, 16'd100, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, 16'd100, 1'b1, 1'b1)};
      plan.push_back(row);
      row = '{make_cmd(REQ_TOUCH_OFF, 16'd0, 0, 16'd0, 1'b1), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, 16'd100, 1'b1, 1'b1)};
      plan.push_back(row);
      // same reading as the reset value of the last zoom: inside the deadband
      row = '{make_cmd(REQ_ZOOM, far_up, 0, 16'd0, 1'b0), 1'b1,
              motor_view(16'd0, 1'b0, DIR_IDLE, 1'b0, 16'd100, 1'b1, 1'b1)};
      plan.push_back(row);
      // zoom below every threshold: falls through to the last valid slot
      plan.push_back('{make_cmd(REQ_ZOOM, 16'd0, 0, 16'd0, 1'b0), 1'b0, no_view});
      // zoom at the top: first slot, first-entry offset path
      plan.push_back('{make_cmd(REQ_ZOOM, far_up, 0, 16'd0, 1'b0), 1'b0, no_view});
      plan.push_back('{make_cmd(REQ_ZOOM, 16'd30000, 0, 16'd0, 1'b0), 1'b0, no_view});
      plan.push_back('{make_cmd(REQ_TICK, 16'd0, 0, 16'd0, 1'b0), 1'b0, no_view});
      // power off freezes motion without clearing it
      plan.push_back('{make_cmd(REQ_POWER, 16'd0, 0, 16'd0, 1'b0), 1'b0, no_view});
      plan.push_back('{make_cmd(REQ_TICK, 16'd0, 0, 16'd0, 1'b0), 1'b0, no_view});
      plan.push_back('{make_cmd(REQ_MOVE_UP, 16'd0, 0, 16'd0, 1'b0), 1'b0, no_view});
      plan.push_back('{make_cmd(REQ_LOAD, far_up, 63, far_up, 1'b0), 1'b0, no_view});
      plan.push_back('{make_cmd(4'd9, 16'd0, 0, 16'd0, 1'b0), 1'b0, no_view});

      foreach (plan[j])
         issue(plan[j].cmd, plan[j].typed, plan[j].want);

      run_phase(PHASE_ITEMS, 34);

      // Phase 1: widest limits, offsets that saturate, full table.
      drain(8);
      program_regs(16'd0, POS_MAX, 16'd1, POS_MAX, 16'd0, POS_MAX, 16'd0, 16'd64);
      run_phase(PHASE_ITEMS, 34);

      // Phase 2: narrow window, both offsets subtract, single entry.
      drain(8);
      program_regs(16'd100, 16'd400, 16'd1, 16'd1234, 16'd1, 16'd500, 16'd1, 16'd1);
      run_phase(PHASE_ITEMS, 67);

      // Phase 3: inverted limits stop every move; sync off; count of zero.
      drain(8);
      program_regs(POS_MAX, 16'd0, 16'd0, $urandom, 16'd1, $urandom, 16'd0, 16'd0);
      run_phase(PHASE_ITEMS, 67);

      // Phase 4: random window, count beyond the table depth, junk upper bits.
      drain(8);
      program_regs($urandom_range(0, 300), $urandom_range(200, 20000), 16'h0003, $urandom,
                   $urandom_range(1), $urandom, 16'd1, 16'd127);
      run_phase(PHASE_ITEMS, 0);

      // Phase 5: moderate offsets, random table size.
      drain(8);
      program_regs(16'd0, LIMIT_MAX_RST, 16'd1, $urandom_range(0, 2000), 16'd1,
                   $urandom_range(0, 2000), 16'd0, $urandom_range(1, 64));
      run_phase(PHASE_ITEMS, 0);

      // let the longest lookup finish before the summary
      drain(80);

      $display("run covered %0d items and %0d results over six register settings",
               items_sent, results_seen);
      $display("%0d zoom lookups, %0d arrivals on target, %0d limit stops",
               lookups, arrivals, limit_stops);
      if (mismatches == 0 && expected_states.size() == 0)
         $display("zoom_tracking_focus_stepper_tb passed");
      else
         $display("zoom_tracking_focus_stepper_tb failed");
      $finish;
   end

endmodule
